[hdl/deq_pkg.sv]
// deq_pkg: operation codes, address selects and the command/status structs
// shared by the deque controller, the datapath and the top level
// no dependencies

package deq_pkg;

  localparam int unsigned FuncWidth = 3;

  localparam logic [FuncWidth-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FuncWidth-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FuncWidth-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FuncWidth-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FuncWidth-1:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [FuncWidth-1:0] FUNC_PEEK_BACK  = 3'd5;
  localparam logic [FuncWidth-1:0] FUNC_CLEAR      = 3'd6;

  // which ring slot the store port touches
  typedef enum logic [1:0] {
    ADDR_FRONT     = 2'd0,
    ADDR_FRONT_NEW = 2'd1,
    ADDR_BACK      = 2'd2,
    ADDR_BACK_LAST = 2'd3
  } addr_sel_e;

  typedef struct packed {
    logic      load;
    logic      exec;
    logic      mem_we;
    logic      mem_re;
    addr_sel_e addr_sel;
    logic      head_dec;
    logic      head_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      ok;
  } deq_cmd_t;

  typedef struct packed {
    logic [FuncWidth-1:0] func;
    logic                 empty;
    logic                 full;
  } deq_stat_t;

endpackage

[hdl/double_ended_queue_unit.sv]
// double_ended_queue_unit: top level of the fixed-capacity deque
// depends on deq_pkg, deq_ctrl and deq_dpath
//
// usage:
//   an item (func_i, push_value_i) is taken at a rising edge where start
//   is high and busy is low. func_i picks push front/back, pop front/back,
//   peek front/back or clear; push_value_i only matters for pushes.
//   every item gives one result: ok_o, read_value_o, count_o, empty_res_o,
//   valid for exactly the one cycle in which done_o is high.
// sequence:
//   busy is high in the cycle after acceptance, while the single port of the
//   ring store is written or read and the head and count update; the result
//   shows in the cycle after that, while done_o is high.
//   the next item can be taken in the cycle the result is shown, but not
//   while busy is high.
// reset:
//   rst_ni clears head index and entry count, the deque comes up empty.
//   store contents are not cleared; only live entries are ever read.
// the receiver cannot stall: each result is taken in its done_o cycle.

module double_ended_queue_unit #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [deq_pkg::FuncWidth-1:0] func_i,
  input  logic [VALUE_WIDTH-1:0]        push_value_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [VALUE_WIDTH-1:0]        read_value_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o,
  output logic                          empty_res_o
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  deq_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          ($clog2(DEPTH + 1))
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (func_i),
    .push_value_i (push_value_i),
    .stat_o       (stat),
    .ok_o         (ok_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o)
  );

endmodule

[hdl/deq_ctrl.sv]
// deq_ctrl: sequencing state machine of the deque, decodes the latched
// operation into datapath commands
// depends on deq_pkg

module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  deq_pkg::deq_stat_t stat_i,
  output deq_pkg::deq_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    case (state_q)
      StIdle:  state_d = start_i ? StExec : StIdle;
      StExec:  state_d = StResp;
      StResp:  state_d = start_i ? StExec : StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q == StExec);
  assign done_o = (state_q == StResp);

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = deq_pkg::ADDR_FRONT;
    // a new item can be taken while the previous result is shown
    cmd_o.load     = start_i && (state_q != StExec);
    cmd_o.exec     = (state_q == StExec);
    if (state_q == StExec) begin
      case (stat_i.func)
        deq_pkg::FUNC_PUSH_FRONT: begin
          if (!stat_i.full) begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.addr_sel = deq_pkg::ADDR_FRONT_NEW;
            cmd_o.head_dec = 1'b1;
            cmd_o.cnt_inc  = 1'b1;
            cmd_o.ok       = 1'b1;
          end
        end
        deq_pkg::FUNC_PUSH_BACK: begin
          if (!stat_i.full) begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.addr_sel = deq_pkg::ADDR_BACK;
            cmd_o.cnt_inc  = 1'b1;
            cmd_o.ok       = 1'b1;
          end
        end
        deq_pkg::FUNC_POP_FRONT: begin
          if (!stat_i.empty) begin
            cmd_o.mem_re   = 1'b1;
            cmd_o.head_inc = 1'b1;
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.ok       = 1'b1;
          end
        end
        deq_pkg::FUNC_POP_BACK: begin
          if (!stat_i.empty) begin
            cmd_o.mem_re   = 1'b1;
            cmd_o.addr_sel = deq_pkg::ADDR_BACK_LAST;
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.ok       = 1'b1;
          end
        end
        deq_pkg::FUNC_PEEK_FRONT: begin
          if (!stat_i.empty) begin
            cmd_o.mem_re = 1'b1;
            cmd_o.ok     = 1'b1;
          end
        end
        deq_pkg::FUNC_PEEK_BACK: begin
          if (!stat_i.empty) begin
            cmd_o.mem_re   = 1'b1;
            cmd_o.addr_sel = deq_pkg::ADDR_BACK_LAST;
            cmd_o.ok       = 1'b1;
          end
        end
        deq_pkg::FUNC_CLEAR: begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.ok      = 1'b1;
        end
        default: begin
          cmd_o.ok = 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/deq_dpath.sv]
// deq_dpath: ring store, head index, entry count and result registers
// of the deque; driven by commands from deq_ctrl
// depends on deq_pkg

module deq_dpath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CW          = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  deq_pkg::deq_cmd_t                cmd_i,
  input  logic [deq_pkg::FuncWidth-1:0]    func_i,
  input  logic [VALUE_WIDTH-1:0]           push_value_i,
  output deq_pkg::deq_stat_t               stat_o,
  output logic                             ok_o,
  output logic [VALUE_WIDTH-1:0]           read_value_o,
  output logic [CW-1:0]                    count_o,
  output logic                             empty_res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = AW + 1;

  logic [deq_pkg::FuncWidth-1:0] func_q;
  logic [VALUE_WIDTH-1:0]        value_q;
  logic [AW-1:0]                 head_q, head_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          ok_q;
  logic                          rd_sel_q;
  logic [VALUE_WIDTH-1:0]        rd_data_q;
  logic [VALUE_WIDTH-1:0]        mem [DEPTH];

  logic [SW-1:0] back_sum, last_sum;
  logic [AW-1:0] back_idx, last_idx, head_prev, head_next, addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= push_value_i;
    end
  end

  // ring index arithmetic, DEPTH need not be a power of two
  assign back_sum  = SW'(head_q) + SW'(cnt_q);
  assign last_sum  = back_sum - SW'(1);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign last_idx  = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
  assign head_prev = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      deq_pkg::ADDR_FRONT:     addr = head_q;
      deq_pkg::ADDR_FRONT_NEW: addr = head_prev;
      deq_pkg::ADDR_BACK:      addr = back_idx;
      deq_pkg::ADDR_BACK_LAST: addr = last_idx;
      default:                 addr = head_q;
    endcase
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = head_prev;
    end else if (cmd_i.head_inc) begin
      head_d = head_next;
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      cnt_q    <= '0;
      ok_q     <= 1'b0;
      rd_sel_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      if (cmd_i.exec) begin
        ok_q     <= cmd_i.ok;
        rd_sel_q <= cmd_i.mem_re;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[addr] <= value_q;
    end
    if (cmd_i.mem_re) begin
      rd_data_q <= mem[addr];
    end
  end

  assign stat_o.func  = func_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));

  assign ok_o         = ok_q;
  assign read_value_o = rd_sel_q ? rd_data_q : '0;
  assign count_o      = cnt_q;
  assign empty_res_o  = (cnt_q == '0);

endmodule

[tb/sv/tb_double_ended_queue_unit.sv]
// tb_double_ended_queue_unit: self-checking bench for the fixed-capacity deque
// a directed table is followed by random traffic; each result is checked against
// the ring model or a pinned row's own result; needs deq_pkg, double_ended_queue_unit
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH  = $clog2(DEPTH + 1);
  localparam int unsigned SLOT_WIDTH   = $clog2(DEPTH);
  localparam logic [deq_pkg::FuncWidth-1:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic                   ok;
    logic [VALUE_WIDTH-1:0] read_value;
    logic [COUNT_WIDTH-1:0] count;
    logic                   empty;
  } deq_result_t;

  typedef struct packed {
    logic [deq_pkg::FuncWidth-1:0] func;
    logic [VALUE_WIDTH-1:0]        value;
    logic [4:0]                    reps;
    logic                          pinned;
    deq_result_t                   result;
  } stim_row_t;

  // a pinned item carries its own expected result instead of the model's
  typedef struct packed {
    logic        pinned;
    deq_result_t result;
  } item_tag_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_e;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          start        = 1'b0;
  logic                          busy;
  logic [deq_pkg::FuncWidth-1:0] func_i       = deq_pkg::FUNC_CLEAR;
  logic [VALUE_WIDTH-1:0]        push_value_i = '0;
  logic                          done_o;
  logic                          ok_o;
  logic [VALUE_WIDTH-1:0]        read_value_o;
  logic [COUNT_WIDTH-1:0]        count_o;
  logic                          empty_res_o;

  // ring model of the deque
  logic [VALUE_WIDTH-1:0] ring_mem [DEPTH];
  logic [SLOT_WIDTH-1:0]  front_slot = '0;
  logic [COUNT_WIDTH-1:0] fill_level = '0;

  deq_result_t pending_results [$];
  item_tag_t   item_tags [$];
  stim_row_t   directed_rows [$];
  int unsigned failure_count = 0;
  int unsigned cycle_count   = 0;

  double_ended_queue_unit #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .push_value_i (push_value_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_ended_queue_unit test failed");
      $finish;
    end
  end

  function automatic deq_result_t apply_deque_op(logic [deq_pkg::FuncWidth-1:0] f,
                                                 logic [VALUE_WIDTH-1:0]        v);
    deq_result_t           r;
    logic [SLOT_WIDTH-1:0] back_slot;
    r = '0;
    back_slot = front_slot + fill_level[SLOT_WIDTH-1:0] - 1'b1;
    case (f)
      deq_pkg::FUNC_PUSH_FRONT: begin
        if (fill_level < DEPTH) begin
          front_slot = front_slot - 1'b1;
          ring_mem[front_slot] = v;
          fill_level = fill_level + 1'b1;
          r.ok = 1'b1;
        end
      end
      deq_pkg::FUNC_PUSH_BACK: begin
        if (fill_level < DEPTH) begin
          ring_mem[front_slot + fill_level[SLOT_WIDTH-1:0]] = v;
          fill_level = fill_level + 1'b1;
          r.ok = 1'b1;
        end
      end
      deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_PEEK_FRONT: begin
        if (fill_level != 0) begin
          r.read_value = ring_mem[front_slot];
          r.ok = 1'b1;
          if (f == deq_pkg::FUNC_POP_FRONT) begin
            front_slot = front_slot + 1'b1;
            fill_level = fill_level - 1'b1;
          end
        end
      end
      deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_PEEK_BACK: begin
        if (fill_level != 0) begin
          r.read_value = ring_mem[back_slot];
          r.ok = 1'b1;
          if (f == deq_pkg::FUNC_POP_BACK) fill_level = fill_level - 1'b1;
        end
      end
      deq_pkg::FUNC_CLEAR: begin
        // head stays where it is
        fill_level = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = fill_level;
    r.empty = (fill_level == 0);
    return r;
  endfunction

  task automatic log_failure(string what, deq_result_t want, deq_result_t got);
    failure_count++;
    if (failure_count <= MAX_REPORTS) begin
      $display("%0t %s: expected ok=%0b value=%h count=%0d empty=%0b",
               $realtime, what, want.ok, want.read_value, want.count, want.empty);
      $display("  got ok=%0b value=%h count=%0d empty=%0b",
               got.ok, got.read_value, got.count, got.empty);
    end
  endtask

  // results are checked before a new item is taken at the same edge
  always @(posedge clk_i) begin : check_and_predict
    deq_result_t got;
    deq_result_t want;
    deq_result_t predicted;
    item_tag_t   tag;
    if (rst_ni) begin
      if (done_o) begin
        got = {ok_o, read_value_o, count_o, empty_res_o};
        if (pending_results.size() == 0) begin
          log_failure("result with no item waiting", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok || got.read_value !== want.read_value ||
              got.count !== want.count || got.empty !== want.empty)
            log_failure("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        predicted = apply_deque_op(func_i, push_value_i);
        tag = item_tags.pop_front();
        pending_results.push_back(tag.pinned ? tag.result : predicted);
      end
    end
  end

  task automatic add_row(logic [deq_pkg::FuncWidth-1:0] f, logic [VALUE_WIDTH-1:0] v,
                         logic [4:0] reps, logic pinned, logic ok,
                         logic [VALUE_WIDTH-1:0] rd, logic [COUNT_WIDTH-1:0] cnt,
                         logic empty);
    stim_row_t row;
    row.func   = f;
    row.value  = v;
    row.reps   = reps;
    row.pinned = pinned;
    row.result = {ok, rd, cnt, empty};
    directed_rows.push_back(row);
  endtask

  task automatic send_item(logic [deq_pkg::FuncWidth-1:0] f, logic [VALUE_WIDTH-1:0] v,
                           logic pinned, deq_result_t r);
    item_tag_t tag;
    tag.pinned = pinned;
    tag.result = r;
    item_tags.push_back(tag);
    start        <= 1'b1;
    func_i       <= f;
    push_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i);
    while (pending_results.size() != 0 || item_tags.size() != 0);
  endtask

  initial begin : stimulus
    stim_row_t                     row;
    op_mix_e                       mix;
    logic                          gaps_on;
    logic [deq_pkg::FuncWidth-1:0] f;
    logic [VALUE_WIDTH-1:0]        v;
    int unsigned                   push_pct;
    int unsigned                   roll;

    mix     = MIX_EVEN;
    gaps_on = 1'b0;

    // empty deque: every read fails, unused code and clear leave it empty
    add_row(deq_pkg::FUNC_POP_FRONT,  '0, 5'd1, 1'b1, 1'b0, '0, 5'd0, 1'b1);
    add_row(deq_pkg::FUNC_POP_BACK,   '0, 5'd1, 1'b1, 1'b0, '0, 5'd0, 1'b1);
    add_row(deq_pkg::FUNC_PEEK_FRONT, '0, 5'd1, 1'b1, 1'b0, '0, 5'd0, 1'b1);
    add_row(deq_pkg::FUNC_PEEK_BACK,  '0, 5'd1, 1'b1, 1'b0, '0, 5'd0, 1'b1);
    add_row(FUNC_UNUSED,              '1, 5'd1, 1'b1, 1'b0, '0, 5'd0, 1'b1);
    add_row(deq_pkg::FUNC_CLEAR,      '0, 5'd1, 1'b1, 1'b1, '0, 5'd0, 1'b1);
    // value extremes at both ends
    add_row(deq_pkg::FUNC_PUSH_BACK,  '1, 5'd1, 1'b1, 1'b1, '0, 5'd1, 1'b0);
    add_row(deq_pkg::FUNC_PUSH_FRONT, '0, 5'd1, 1'b1, 1'b1, '0, 5'd2, 1'b0);
    add_row(deq_pkg::FUNC_PEEK_FRONT, '0, 5'd1, 1'b1, 1'b1, '0, 5'd2, 1'b0);
    add_row(deq_pkg::FUNC_PEEK_BACK,  '0, 5'd1, 1'b1, 1'b1, '1, 5'd2, 1'b0);
    add_row(deq_pkg::FUNC_POP_BACK,   '0, 5'd1, 1'b1, 1'b1, '1, 5'd1, 1'b0);
    add_row(deq_pkg::FUNC_POP_FRONT,  '0, 5'd1, 1'b1, 1'b1, '0, 5'd0, 1'b1);
    // fill from both ends, head wraps below slot zero
    add_row(deq_pkg::FUNC_PUSH_FRONT, 32'h5555_AAAA, 5'd8, 1'b0, 1'b0, '0, 5'd0, 1'b0);
    add_row(deq_pkg::FUNC_PUSH_BACK,  32'hAAAA_5555, 5'd8, 1'b0, 1'b0, '0, 5'd0, 1'b0);
    // full deque: pushes fail and change nothing; then reads at both ends and a clear
    add_row(deq_pkg::FUNC_PUSH_BACK,  32'h1234_5678, 5'd1, 1'b1, 1'b0, '0, 5'd16, 1'b0);
    add_row(deq_pkg::FUNC_PUSH_FRONT, 32'h8765_4321, 5'd1, 1'b1, 1'b0, '0, 5'd16, 1'b0);
    add_row(FUNC_UNUSED,              '0, 5'd1, 1'b1, 1'b0, '0, 5'd16, 1'b0);
    add_row(deq_pkg::FUNC_PEEK_FRONT, '0, 5'd1, 1'b1, 1'b1, 32'h5555_AAAA, 5'd16, 1'b0);
    add_row(deq_pkg::FUNC_POP_BACK,   '0, 5'd1, 1'b1, 1'b1, 32'hAAAA_5555, 5'd15, 1'b0);
    add_row(deq_pkg::FUNC_CLEAR,      '0, 5'd1, 1'b1, 1'b1, '0, 5'd0, 1'b1);
    add_row(deq_pkg::FUNC_PEEK_BACK,  '0, 5'd1, 1'b1, 1'b0, '0, 5'd0, 1'b1);
    // after clear the head is kept
    add_row(deq_pkg::FUNC_PUSH_BACK,  32'hFEDC_BA98, 5'd1, 1'b0, 1'b0, '0, 5'd0, 1'b0);
    add_row(deq_pkg::FUNC_POP_FRONT,  '0, 5'd1, 1'b0, 1'b0, '0, 5'd0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      repeat (row.reps) send_item(row.func, row.value, row.pinned, row.result);
    end
    wait_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // traffic mix and idling change every few dozen items
      if (n % 60 == 0) begin
        mix     = op_mix_e'($urandom_range(2));
        gaps_on = ($urandom_range(2) != 0);
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (gaps_on && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(3) == 0) begin
        start        <= 1'b0;
        func_i       <= deq_pkg::FuncWidth'($urandom);
        push_value_i <= $urandom;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
      end

      push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 34;
      roll = $urandom_range(99);
      if (roll < 2) begin
        f = FUNC_UNUSED;
      end else if (roll < 4) begin
        f = deq_pkg::FUNC_CLEAR;
      end else if ($urandom_range(99) < push_pct) begin
        f = $urandom_range(1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
      end else begin
        case ($urandom_range(3))
          0:       f = deq_pkg::FUNC_POP_FRONT;
          1:       f = deq_pkg::FUNC_POP_BACK;
          2:       f = deq_pkg::FUNC_PEEK_FRONT;
          default: f = deq_pkg::FUNC_PEEK_BACK;
        endcase
      end
      case ($urandom_range(7))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom;
      endcase
      send_item(f, v, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dpath.sv
hdl/double_ended_queue_unit.sv
tb/sv/tb_double_ended_queue_unit.sv
